// ----- src/tree_lca_binary_lifting_assert.svh -----
// Assertion macros for the LCA binary-lifting block.
// Included by the top level; needs no other file.
`ifndef TREE_LCA_BINARY_LIFTING_ASSERT_SVH
`define TREE_LCA_BINARY_LIFTING_ASSERT_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expr must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ----- src/lca_pkg.sv -----
// Shared constants, types and helper functions for the LCA binary-lifting block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lca_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int LIFT_LEVELS = 10;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int ANC_W       = NODE_W + 1;
   localparam int DEPTH_W     = 11;
   localparam int LEVEL_W     = $clog2(DEPTH_W + 1);
   localparam int ANC_DEPTH   = MAX_NODES * LIFT_LEVELS;
   localparam int ANC_ADDR_W  = $clog2(ANC_DEPTH);

   typedef logic [1:0]            op_type;
   typedef logic [NODE_W-1:0]     node_type;
   typedef logic [ANC_W-1:0]      anc_type;
   typedef logic [DEPTH_W-1:0]    depth_type;
   typedef logic [LEVEL_W-1:0]    level_type;
   typedef logic [ANC_ADDR_W-1:0] anc_addr_type;

   localparam op_type OP_ATTACH = 2'd0;
   localparam op_type OP_ROOT   = 2'd1;
   localparam op_type OP_QUERY  = 2'd2;

   // ancestor value meaning "none"
   localparam anc_type   NO_NODE   = anc_type'(MAX_NODES);
   localparam depth_type DEPTH_MAX = '1;

   // requests from the sequencer to the table memories
   typedef struct packed {
      node_type     dep_raddr;
      logic         dep_we;
      node_type     dep_waddr;
      depth_type    dep_wdata;
      anc_addr_type anc_raddr_a;
      anc_addr_type anc_raddr_b;
      logic         anc_we;
      anc_addr_type anc_waddr;
      anc_type      anc_wdata;
   } tbl_req_type;

   // registered read data, arriving in the cycle after the request
   typedef struct packed {
      depth_type dep_rdata;
      anc_type   anc_rdata_a;
      anc_type   anc_rdata_b;
   } tbl_rsp_type;

   function automatic level_type flog2(input depth_type v);
      level_type r;
      r = '0;
      for (int k = 1; k < DEPTH_W; k++) begin
         if (v[k]) r = level_type'(k);
      end
      return r;
   endfunction

   function automatic anc_addr_type anc_addr(input node_type n, input level_type lvl);
      return anc_addr_type'(n) * anc_addr_type'(LIFT_LEVELS) + anc_addr_type'(lvl);
   endfunction

endpackage
`default_nettype wire

// ----- src/lca_tables.sv -----
// Depth table and ancestor table memories, one write and registered reads.
// Depends on lca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lca_tables
   import lca_pkg::*;
(
   input  wire logic        clock,
   input  wire tbl_req_type tbl_req,
   output tbl_rsp_type      tbl_rsp
);

   depth_type depth_mem [MAX_NODES];
   anc_type   anc_mem   [ANC_DEPTH];

   depth_type dep_rdata_ff;
   anc_type   anc_rdata_a_ff;
   anc_type   anc_rdata_b_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.dep_we) begin
         depth_mem[tbl_req.dep_waddr] <= tbl_req.dep_wdata;
      end
      dep_rdata_ff <= depth_mem[tbl_req.dep_raddr];
   end

   always_ff @(posedge clock) begin
      if (tbl_req.anc_we) begin
         anc_mem[tbl_req.anc_waddr] <= tbl_req.anc_wdata;
      end
      anc_rdata_a_ff <= anc_mem[tbl_req.anc_raddr_a];
      anc_rdata_b_ff <= anc_mem[tbl_req.anc_raddr_b];
   end

   assign tbl_rsp.dep_rdata   = dep_rdata_ff;
   assign tbl_rsp.anc_rdata_a = anc_rdata_a_ff;
   assign tbl_rsp.anc_rdata_b = anc_rdata_b_ff;

endmodule
`default_nettype wire

// ----- src/lca_seq.sv -----
// Sequencer for attach and query words: walks the tables, waiting on each registered read.
// Depends on lca_pkg; drives lca_tables through tbl_req/tbl_rsp.
`timescale 1ns / 1ps
`default_nettype none
module lca_seq
   import lca_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire op_type      req_op,
   input  wire node_type    req_first_node,
   input  wire node_type    req_second_node,
   output tbl_req_type      tbl_req,
   input  wire tbl_rsp_type tbl_rsp,
   output logic             rsp_valid,
   output node_type         rsp_ancestor_node
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_A_DEP     = 4'd2;
   localparam logic [3:0] S_A_LOOP    = 4'd3;
   localparam logic [3:0] S_A_READ    = 4'd4;
   localparam logic [3:0] S_Q_DEPB    = 4'd5;
   localparam logic [3:0] S_Q_SWAP    = 4'd6;
   localparam logic [3:0] S_Q_LIFT    = 4'd7;
   localparam logic [3:0] S_Q_LIFTRD  = 4'd8;
   localparam logic [3:0] S_Q_CMP     = 4'd9;
   localparam logic [3:0] S_Q_TOPDEP  = 4'd10;
   localparam logic [3:0] S_Q_CLIMB   = 4'd11;
   localparam logic [3:0] S_Q_CLIMBRD = 4'd12;
   localparam logic [3:0] S_Q_FINAL   = 4'd13;
   localparam logic [3:0] S_Q_FINALRD = 4'd14;

   localparam level_type TOP_LEVEL = level_type'(LIFT_LEVELS - 1);
   localparam level_type NUM_LEVEL = level_type'(LIFT_LEVELS);

   logic [3:0] state_ff, state_in;
   op_type     op_ff, op_in;
   node_type   a_ff, a_in;
   node_type   b_ff, b_in;
   anc_type    x_ff, x_in;
   anc_type    y_ff, y_in;
   depth_type  dx_ff, dx_in;
   depth_type  diff_ff, diff_in;
   level_type  top_ff, top_in;
   level_type  lvl_ff, lvl_in;
   logic       rsp_valid_ff, rsp_valid_in;
   node_type   rsp_node_ff, rsp_node_in;

   // derived values
   depth_type dep_new;
   anc_type   parent;
   level_type lift_raw, lift_s, dep_log, climb_top, lvl_dn;
   depth_type lift_step;
   logic      x_nil, y_nil;
   anc_type   ax, ay;

   // new node depth saturates; a root sits at depth one
   assign dep_new = (op_ff == OP_ROOT) ? depth_type'(1) :
                    (tbl_rsp.dep_rdata == DEPTH_MAX) ? DEPTH_MAX :
                    depth_type'(tbl_rsp.dep_rdata + 1'b1);
   assign parent    = (op_ff == OP_ROOT) ? NO_NODE : {1'b0, b_ff};
   assign lift_raw  = flog2(diff_ff);
   assign lift_s    = (lift_raw > TOP_LEVEL) ? TOP_LEVEL : lift_raw;
   assign lift_step = depth_type'(1) << lift_s;
   assign dep_log   = level_type'(flog2(tbl_rsp.dep_rdata) + 1'b1);
   assign climb_top = (tbl_rsp.dep_rdata == '0) ? '0 :
                      (dep_log > NUM_LEVEL) ? NUM_LEVEL : dep_log;
   assign lvl_dn    = level_type'(lvl_ff - 1'b1);
   assign x_nil     = (x_ff >= NO_NODE);
   assign y_nil     = (y_ff >= NO_NODE);
   assign ax        = x_nil ? NO_NODE : tbl_rsp.anc_rdata_a;
   assign ay        = y_nil ? NO_NODE : tbl_rsp.anc_rdata_b;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dx_in        = dx_ff;
      diff_in      = diff_ff;
      top_in       = top_ff;
      lvl_in       = lvl_ff;
      rsp_valid_in = 1'b0;
      rsp_node_in  = rsp_node_ff;
      tbl_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_op;
               a_in     = req_first_node;
               b_in     = req_second_node;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (op_ff)
               OP_ATTACH, OP_ROOT: begin
                  tbl_req.dep_raddr = b_ff;
                  state_in          = S_A_DEP;
               end
               OP_QUERY: begin
                  tbl_req.dep_raddr = a_ff;
                  state_in          = S_Q_DEPB;
               end
               default: state_in = S_IDLE;
            endcase
         end
         // attach: depth and level zero, then levels one by one
         S_A_DEP: begin
            tbl_req.dep_we    = 1'b1;
            tbl_req.dep_waddr = a_ff;
            tbl_req.dep_wdata = dep_new;
            tbl_req.anc_we    = 1'b1;
            tbl_req.anc_waddr = anc_addr(a_ff, '0);
            tbl_req.anc_wdata = parent;
            x_in              = parent;
            top_in            = flog2(dep_new);
            lvl_in            = level_type'(1);
            state_in          = S_A_LOOP;
         end
         S_A_LOOP: begin
            if (lvl_ff == NUM_LEVEL) begin
               state_in = S_IDLE;
            end else if (lvl_ff <= top_ff && !x_nil) begin
               tbl_req.anc_raddr_a = anc_addr(x_ff[NODE_W-1:0], lvl_dn);
               state_in            = S_A_READ;
            end else begin
               tbl_req.anc_we    = 1'b1;
               tbl_req.anc_waddr = anc_addr(a_ff, lvl_ff);
               tbl_req.anc_wdata = NO_NODE;
               x_in              = NO_NODE;
               lvl_in            = level_type'(lvl_ff + 1'b1);
            end
         end
         S_A_READ: begin
            tbl_req.anc_we    = 1'b1;
            tbl_req.anc_waddr = anc_addr(a_ff, lvl_ff);
            tbl_req.anc_wdata = tbl_rsp.anc_rdata_a;
            x_in              = tbl_rsp.anc_rdata_a;
            lvl_in            = level_type'(lvl_ff + 1'b1);
            state_in          = S_A_LOOP;
         end
         // query: both depths, deeper node first
         S_Q_DEPB: begin
            dx_in             = tbl_rsp.dep_rdata;
            tbl_req.dep_raddr = b_ff;
            state_in          = S_Q_SWAP;
         end
         S_Q_SWAP: begin
            if (dx_ff < tbl_rsp.dep_rdata) begin
               x_in    = {1'b0, b_ff};
               y_in    = {1'b0, a_ff};
               diff_in = depth_type'(tbl_rsp.dep_rdata - dx_ff);
            end else begin
               x_in    = {1'b0, a_ff};
               y_in    = {1'b0, b_ff};
               diff_in = depth_type'(dx_ff - tbl_rsp.dep_rdata);
            end
            state_in = S_Q_LIFT;
         end
         S_Q_LIFT: begin
            if (diff_ff == '0) begin
               state_in = S_Q_CMP;
            end else begin
               diff_in = depth_type'(diff_ff - lift_step);
               if (!x_nil) begin
                  tbl_req.anc_raddr_a = anc_addr(x_ff[NODE_W-1:0], lift_s);
                  state_in            = S_Q_LIFTRD;
               end
            end
         end
         S_Q_LIFTRD: begin
            x_in     = tbl_rsp.anc_rdata_a;
            state_in = S_Q_LIFT;
         end
         S_Q_CMP: begin
            if (x_ff == y_ff || x_nil) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = x_nil ? '0 : x_ff[NODE_W-1:0];
               state_in     = S_IDLE;
            end else begin
               tbl_req.dep_raddr = x_ff[NODE_W-1:0];
               state_in          = S_Q_TOPDEP;
            end
         end
         S_Q_TOPDEP: begin
            lvl_in   = climb_top;
            state_in = S_Q_CLIMB;
         end
         // climb both while ancestors differ, highest level first
         S_Q_CLIMB: begin
            if (lvl_ff == '0) begin
               state_in = S_Q_FINAL;
            end else begin
               tbl_req.anc_raddr_a = anc_addr(x_ff[NODE_W-1:0], lvl_dn);
               tbl_req.anc_raddr_b = anc_addr(y_ff[NODE_W-1:0], lvl_dn);
               state_in            = S_Q_CLIMBRD;
            end
         end
         S_Q_CLIMBRD: begin
            if (ax != ay) begin
               x_in = ax;
               y_in = ay;
            end
            lvl_in   = lvl_dn;
            state_in = S_Q_CLIMB;
         end
         S_Q_FINAL: begin
            if (x_nil) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = '0;
               state_in     = S_IDLE;
            end else begin
               tbl_req.anc_raddr_a = anc_addr(x_ff[NODE_W-1:0], '0);
               state_in            = S_Q_FINALRD;
            end
         end
         S_Q_FINALRD: begin
            rsp_valid_in = 1'b1;
            rsp_node_in  = (tbl_rsp.anc_rdata_a >= NO_NODE) ? '0 :
                           tbl_rsp.anc_rdata_a[NODE_W-1:0];
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      dx_ff       <= dx_in;
      diff_ff     <= diff_in;
      top_ff      <= top_in;
      lvl_ff      <= lvl_in;
      rsp_node_ff <= rsp_node_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ancestor_node = rsp_node_ff;

endmodule
`default_nettype wire

// ----- src/tree_lca_binary_lifting.sv -----
// Top level of the LCA binary-lifting block: sequencer plus table memories.
// Depends on lca_pkg, lca_seq, lca_tables and tree_lca_binary_lifting_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "tree_lca_binary_lifting_assert.svh"
// Usage:
//  - Input word: req_op, req_first_node, req_second_node, taken at a clock edge
//    with start high and busy low. Op attach links first under second, op root
//    makes first a root, op query asks for the LCA of the two; op 3 is dropped.
//  - Result word: only a query makes one. rsp_ancestor_node is valid for the
//    single cycle rsp_valid is high; the receiver cannot stall it.
//  - Work: one word at a time; busy stays high until the word is done.
//    Attach: a depth read, the depth and level 0 write, then per level 1..9
//    a read and write-back while filled, or a write of none once empty.
//    Query: read both depths, one read per lift jump, end the lift, compare;
//    done there when the lifted node is the answer. Otherwise read the depth
//    of the lifted node, a pair of reads per climb level, end the climb, and
//    a final parent read. The result is registered after the last step and
//    shows in the cycle that busy drops.
//  - The pace is set by the ancestor memory accesses: each filled level is a
//    registered read, then a compare or write-back.
//  - Reset clears the sequencer only. Table contents are undefined until a
//    node is attached; querying an unattached node gives an undefined answer.
//  - Depth saturates at 2047; an ancestor of 1024 marks "none".
module tree_lca_binary_lifting
   import lca_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   input  wire op_type   req_op,
   input  wire node_type req_first_node,
   input  wire node_type req_second_node,
   output logic          rsp_valid,
   output node_type      rsp_ancestor_node
);

   tbl_req_type tbl_req;
   tbl_rsp_type tbl_rsp;

   // control and the result register
   lca_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_first_node    (req_first_node),
      .req_second_node   (req_second_node),
      .tbl_req           (tbl_req),
      .tbl_rsp           (tbl_rsp),
      .rsp_valid         (rsp_valid),
      .rsp_ancestor_node (rsp_ancestor_node)
   );

   // depth and ancestor memories, reads registered
   lca_tables u_tables (
      .clock   (clock),
      .tbl_req (tbl_req),
      .tbl_rsp (tbl_rsp)
   );

   // an accepted word always raises busy in the following cycle
   `ASSERT_PROP(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accept without busy")
   // a result word closes out a busy period
   `ASSERT_PROP(a_rsp_after_busy, clock, reset, rsp_valid |-> $past(busy), "result while idle")
   // one word in flight gives at most one result strobe
   `ASSERT_PROP(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "double result strobe")
   // tables change only while a word is being worked on
   `ASSERT_NEVER(a_write_idle, clock, reset, (tbl_req.anc_we || tbl_req.dep_we) && !busy,
                 "table write while idle")

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for tree_lca_binary_lifting: directed table, random words, deep chains.
// Depends on lca_pkg and the tree_lca_binary_lifting RTL in src.
`timescale 1ns / 1ps
module tb_top;
   import lca_pkg::*;

   // Op 3 has no name in the package; the block drops it without a result.
   localparam op_type OP_SPARE = 2'd3;

   // Generous cycle ceiling: a run of under two thousand words, sender gaps
   // included, sits far below this.
   localparam int unsigned RUN_LIMIT = 2_000_000;
   // Room after the last owed answer for a straggler.
   localparam int unsigned DRAIN_CYCLES = 80;
   // Random words per idle phase (ignored op 3 words not counted).
   localparam int unsigned WORDS_PER_PHASE = 170;
   // Nodes recycled by the deep-chain phase.
   localparam int unsigned RING_SIZE = 48;
   // Chain depth to reach, past 1024 so lifts hit the jump cap.
   localparam int unsigned CHAIN_DEPTH = 1040;
   localparam int unsigned STEP_COUNT = 24;

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   op_type   req_op;
   node_type req_first_node;
   node_type req_second_node;
   logic     rsp_valid;
   node_type rsp_ancestor_node;

   tree_lca_binary_lifting DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_first_node    (req_first_node),
      .req_second_node   (req_second_node),
      .rsp_valid         (rsp_valid),
      .rsp_ancestor_node (rsp_ancestor_node)
   );

   // ------------------------------------------------------------------
   // Directed table. want is typed in only where the answer is obvious
   // (same node, plain ancestor, separate trees); other query rows take
   // the tree model's answer.
   // ------------------------------------------------------------------
   typedef struct packed {
      op_type   op;
      node_type first;
      node_type second;
      logic     typed;
      node_type want;
   } step_row_type;

   localparam step_row_type STEP_TABLE [STEP_COUNT] = '{
      '{OP_ROOT,   10'd0,    10'd1023, 1'b0, 10'd0},    // root, second field ignored
      '{OP_ATTACH, 10'd1023, 10'd0,    1'b0, 10'd0},
      '{OP_ATTACH, 10'd512,  10'd1023, 1'b0, 10'd0},
      '{OP_ATTACH, 10'd341,  10'd512,  1'b0, 10'd0},    // 0101010101
      '{OP_ATTACH, 10'd682,  10'd0,    1'b0, 10'd0},    // 1010101010
      '{OP_QUERY,  10'd1023, 10'd1023, 1'b1, 10'd1023}, // same node
      '{OP_QUERY,  10'd0,    10'd0,    1'b1, 10'd0},
      '{OP_QUERY,  10'd341,  10'd682,  1'b1, 10'd0},    // meet at the root
      '{OP_QUERY,  10'd682,  10'd341,  1'b1, 10'd0},    // same, swapped
      '{OP_QUERY,  10'd341,  10'd1023, 1'b1, 10'd1023}, // one is the ancestor
      '{OP_QUERY,  10'd512,  10'd341,  1'b1, 10'd512},
      '{OP_ROOT,   10'd1,    10'd0,    1'b0, 10'd0},    // second tree
      '{OP_ATTACH, 10'd2,    10'd1,    1'b0, 10'd0},
      '{OP_QUERY,  10'd2,    10'd341,  1'b1, 10'd0},    // different trees
      '{OP_SPARE,  10'd1023, 10'd1023, 1'b0, 10'd0},    // dropped, no result
      '{OP_SPARE,  10'd0,    10'd0,    1'b0, 10'd0},
      '{OP_ATTACH, 10'd1023, 10'd1,    1'b0, 10'd0},    // reattach, children keep tables
      '{OP_QUERY,  10'd341,  10'd512,  1'b1, 10'd512},
      '{OP_QUERY,  10'd512,  10'd2,    1'b0, 10'd0},    // through stale tables
      '{OP_ATTACH, 10'd2,    10'd2,    1'b0, 10'd0},    // node under itself
      '{OP_QUERY,  10'd2,    10'd1,    1'b0, 10'd0},
      '{OP_ROOT,   10'd0,    10'd682,  1'b0, 10'd0},    // root made root again
      '{OP_QUERY,  10'd1023, 10'd682,  1'b0, 10'd0},
      '{OP_QUERY,  10'd682,  10'd341,  1'b0, 10'd0}
   };

   // ------------------------------------------------------------------
   // Tree model: depth per node and the 2^i ancestor of every node,
   // NO_NODE standing for "none". Cleared to zero like the block's
   // tables are assumed to be; unwritten entries are never read.
   // ------------------------------------------------------------------
   depth_type tree_depth [MAX_NODES];
   anc_type   tree_up    [MAX_NODES][LIFT_LEVELS];

   // Stimulus bookkeeping: which nodes hold valid entries.
   bit        placed [MAX_NODES];
   node_type  placed_list [$];
   node_type  last_linked;

   node_type  lca_expect [$];   // answers owed by the block, oldest first
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_pct;       // chance in percent that start is held low in a cycle
   int unsigned random_sent;

   function automatic int unsigned log2_floor(input int unsigned v);
      int unsigned r;
      r = 0;
      while (v > 1) begin
         v = v >> 1;
         r++;
      end
      return r;
   endfunction

   // 2^lvl-th ancestor, "none" passes through
   function automatic anc_type hop(input anc_type n, input int unsigned lvl);
      if (n >= NO_NODE || lvl >= LIFT_LEVELS) return NO_NODE;
      return tree_up[n[NODE_W-1:0]][lvl];
   endfunction

   // Attach n under parent (NO_NODE for a root) and fill its levels in order,
   // so a node under itself sees its own fresh level 0.
   function automatic void link_node(input node_type n, input anc_type parent);
      int unsigned d;
      int unsigned top;
      if (parent == NO_NODE) begin
         d = 1;
      end else begin
         d = int'(tree_depth[parent[NODE_W-1:0]]) + 1;
         if (d > DEPTH_MAX) d = DEPTH_MAX;
      end
      tree_depth[n] = depth_type'(d);
      tree_up[n][0] = parent;
      top = log2_floor(d);
      for (int unsigned i = 1; i < LIFT_LEVELS; i++) begin
         tree_up[n][i] = (i <= top) ? hop(tree_up[n][i-1], i - 1) : NO_NODE;
      end
   endfunction

   // Lift the deeper node to equal depth, then climb both from the top
   // level while their ancestors differ. "None" anywhere answers 0.
   function automatic node_type lca_of(input node_type a, input node_type b);
      anc_type     x;
      anc_type     y;
      anc_type     ax;
      anc_type     ay;
      int unsigned diff;
      int unsigned s;
      int unsigned t;
      int unsigned top;
      x = anc_type'(a);
      y = anc_type'(b);
      if (tree_depth[a] < tree_depth[b]) begin
         x = anc_type'(b);
         y = anc_type'(a);
      end
      diff = int'(tree_depth[x[NODE_W-1:0]]) - int'(tree_depth[y[NODE_W-1:0]]);
      // long differences go in jumps of at most 2^(LIFT_LEVELS-1)
      while (diff > 0) begin
         s = log2_floor(diff);
         if (s > LIFT_LEVELS - 1) s = LIFT_LEVELS - 1;
         x = hop(x, s);
         diff = diff - (1 << s);
      end
      if (x == y) return (x < NO_NODE) ? x[NODE_W-1:0] : node_type'(0);
      t = (x < NO_NODE) ? int'(tree_depth[x[NODE_W-1:0]]) : 0;
      top = (t == 0) ? 0 : log2_floor(t) + 1;
      if (top > LIFT_LEVELS) top = LIFT_LEVELS;
      for (int i = int'(top) - 1; i >= 0; i--) begin
         ax = hop(x, i);
         ay = hop(y, i);
         if (ax != ay) begin
            x = ax;
            y = ay;
         end
      end
      ax = hop(x, 0);
      return (ax < NO_NODE) ? ax[NODE_W-1:0] : node_type'(0);
   endfunction

   function automatic node_type any_placed();
      return placed_list[$urandom_range(0, placed_list.size() - 1)];
   endfunction

   function automatic void flag_failure(input string msg);
      if (fail_count < 10) $display("%s", msg);
      fail_count++;
   endfunction

   // ------------------------------------------------------------------
   // Clock and watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Result checker: every strobe must match the oldest owed answer.
   // The block cannot be stalled, so a strobe is a taken word.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (lca_expect.size() == 0) begin
            flag_failure($sformatf("unexpected result word: ancestor %0d", rsp_ancestor_node));
         end else if (rsp_ancestor_node !== lca_expect[0]) begin
            flag_failure($sformatf("ancestor mismatch: expected %0d, got %0d",
                                   lca_expect[0], rsp_ancestor_node));
            void'(lca_expect.pop_front());
         end else begin
            void'(lca_expect.pop_front());
         end
      end
   end

   // ------------------------------------------------------------------
   // Word driver. Called at a falling edge; holds the word and, per
   // cycle, drops start with chance hold_pct, so gaps land anywhere in
   // the block's work. Returns at the falling edge after the word is
   // taken, with start untouched in that step.
   // ------------------------------------------------------------------
   task automatic send_word(input op_type op, input node_type a, input node_type b,
                            input bit typed, input node_type want);
      bit taken;
      taken = 1'b0;
      req_op          <= op;
      req_first_node  <= a;
      req_second_node <= b;
      while (!taken) begin
         start <= ($urandom_range(0, 99) >= hold_pct);
         @(posedge clock);
         taken = start && !busy;
         if (!taken) @(negedge clock);
      end
      if (op == OP_QUERY) begin
         lca_expect.insert(lca_expect.size(), typed ? want : lca_of(a, b));
      end else if (op != OP_SPARE) begin
         link_node(a, (op == OP_ROOT) ? NO_NODE : anc_type'(b));
         if (!placed[a]) begin
            placed[a] = 1'b1;
            placed_list.insert(placed_list.size(), a);
         end
         last_linked = a;
      end
      @(negedge clock);
   endtask

   // One random word. Parents and query nodes always come from placed
   // nodes; new children often hang under the newest node so chains grow.
   task automatic send_random();
      int unsigned roll;
      anc_type     up_node;
      node_type    a;
      node_type    b;
      roll = $urandom_range(0, 99);
      a = node_type'($urandom_range(0, MAX_NODES - 1));
      b = node_type'($urandom_range(0, MAX_NODES - 1));
      if (placed_list.size() < 2 || roll < 5) begin
         send_word(OP_ROOT, a, b, 1'b0, '0);
         random_sent++;
      end else if (roll < 9) begin
         send_word(OP_SPARE, a, b, 1'b0, '0);   // noise, not counted
      end else if (roll < 42) begin
         b = (roll < 26) ? last_linked : any_placed();
         if (roll < 13) a = any_placed();       // reattach a live node
         if (roll == 13) a = b;                 // node under itself
         send_word(OP_ATTACH, a, b, 1'b0, '0);
         random_sent++;
      end else begin
         a = (roll < 60) ? last_linked : any_placed();
         b = any_placed();
         if (roll >= 90) begin
            // against one of its own stored ancestors
            up_node = tree_up[a][$urandom_range(0, 3)];
            b = (up_node < NO_NODE) ? up_node[NODE_W-1:0] : a;
         end
         send_word(OP_QUERY, a, b, 1'b0, '0);
         random_sent++;
      end
   endtask

   // Depth only grows by one per attach, so a ring of nodes is relinked
   // in a loop until the chain tip is past depth 1024. Queries pit the
   // chain tip against ring nodes or any placed node; shallow ones give long multi-jump lifts.
   task automatic grow_deep_chain();
      node_type    ring [RING_SIZE];
      node_type    prev;
      node_type    cur;
      node_type    other;
      int unsigned k;
      for (int i = 0; i < RING_SIZE; i++) ring[i] = node_type'($urandom_range(0, MAX_NODES - 1));
      prev = last_linked;
      k = 0;
      while (tree_depth[prev] < CHAIN_DEPTH) begin
         cur = ring[k % RING_SIZE];
         send_word(OP_ATTACH, cur, prev, 1'b0, '0);
         if (k % 6 == 5) begin
            other = ring[$urandom_range(0, RING_SIZE - 1)];
            if (!placed[other] || k % 12 == 11) other = any_placed();
            send_word(OP_QUERY, cur, other, 1'b0, '0);
         end
         prev = cur;
         k++;
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_op          = OP_ROOT;
      req_first_node  = '0;
      req_second_node = '0;
      hold_pct        = 21;
      random_sent     = 0;
      last_linked     = '0;
      for (int n = 0; n < MAX_NODES; n++) begin
         tree_depth[n] = '0;
         placed[n]     = 1'b0;
         for (int l = 0; l < LIFT_LEVELS; l++) tree_up[n][l] = '0;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender idles in about a fifth of the cycles
      for (int i = 0; i < STEP_COUNT; i++) begin
         send_word(STEP_TABLE[i].op, STEP_TABLE[i].first, STEP_TABLE[i].second,
                   STEP_TABLE[i].typed, STEP_TABLE[i].want);
      end
      while (random_sent < WORDS_PER_PHASE) send_random();

      // sender mostly idle
      hold_pct    = 70;
      random_sent = 0;
      while (random_sent < WORDS_PER_PHASE) send_random();

      // back to back, then the deep chain
      hold_pct    = 0;
      random_sent = 0;
      while (random_sent < WORDS_PER_PHASE) send_random();
      grow_deep_chain();

      start <= 1'b0;
      while (lca_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
